// File: rtl/yep_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yep_pkg
// Shared types and constants of the YUV edge padding expander.
// ----------------------------------------------------------------------------
package yep_pkg;

  localparam int COORD_LIMIT = 4096;
  localparam int PAD_BITS    = 6;
  localparam int QDEPTH      = 4;
  localparam int QAW         = 2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_FILL = 1'b1;

  localparam logic [2:0] REG_CHROMA_FORMAT  = 3'd0;
  localparam logic [2:0] REG_LUMA_WIDTH     = 3'd1;
  localparam logic [2:0] REG_LUMA_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_LUMA_PAD_W     = 3'd3;
  localparam logic [2:0] REG_LUMA_PAD_H     = 3'd4;
  localparam logic [2:0] REG_CHROMA_PAD_W   = 3'd5;
  localparam logic [2:0] REG_CHROMA_PAD_H   = 3'd6;

  localparam logic [2:0] FMT_LUMA_ONLY = 3'd0;
  localparam logic [2:0] FMT_420       = 3'd1;
  localparam logic [2:0] FMT_422       = 3'd2;
  localparam logic [2:0] FMT_411       = 3'd4;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  typedef struct packed {
    logic [2:0]  chroma_format;
    logic [12:0] luma_width;
    logic [12:0] luma_height;
    logic [12:0] luma_padded_width;
    logic [12:0] luma_padded_height;
    logic [12:0] chroma_padded_width;
    logic [12:0] chroma_padded_height;
  } cfg_t;

  typedef struct packed {
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] len;
    logic [12:0] ph;
  } geo_t;

  // One request for the back end: a run of results starting at col.
  typedef struct packed {
    logic                is_fill;
    logic [9:0]          value;
    logic [1:0]          plane;
    logic [11:0]         row;
    logic [11:0]         col;
    logic [PAD_BITS-1:0] count_m1;
    logic                plane_done;
    logic                frame_done;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/yep_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yep_front
// Configuration registers, plane geometry and position counters. Turns each
// accepted request into one job for the back end, or drops it.
// ----------------------------------------------------------------------------
module yep_front #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_RIGHT_PAD = 63
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_wr_en,
  input  wire [2:0]        cfg_index,
  input  wire [12:0]       cfg_data,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              in_cmd,
  input  wire [7:0]        in_sample,
  output logic             push_valid,
  output yep_pkg::job_t    push_job,
  input  wire              push_ready
);

  localparam int WCAP = (MAX_WIDTH < yep_pkg::COORD_LIMIT) ? MAX_WIDTH : yep_pkg::COORD_LIMIT;
  localparam logic [12:0] WCAP_W  = 13'(WCAP);
  localparam logic [12:0] HCAP_W  = 13'(yep_pkg::COORD_LIMIT);
  localparam logic [12:0] PAD_W   = 13'(MAX_RIGHT_PAD);

  yep_pkg::cfg_t cfg;
  logic [11:0]   col_count;
  logic [11:0]   row_count;
  logic [1:0]    plane_index;
  logic          fill_phase;

  logic [11:0]   col_count_next;
  logic [11:0]   row_count_next;
  logic [1:0]    plane_index_next;
  logic          fill_phase_next;

  yep_pkg::geo_t geo;
  logic          accept;
  logic [12:0]   h_m1;
  logic [12:0]   w_m1;
  logic [12:0]   len_m1;
  logic [12:0]   ph_m1;
  logic [11:0]   r;
  logic [11:0]   c;
  logic          row_end;
  logic          col_end;
  logic          finish;
  logic [12:0]   pad_run;

  function automatic yep_pkg::geo_t plane_geo(input logic chroma, input yep_pkg::cfg_t g);
    yep_pkg::geo_t res;
    logic [12:0]   aw;
    logic [12:0]   ah;
    logic [12:0]   pw;
    logic [12:0]   pht;
    logic [12:0]   pad;
    if (!chroma) begin
      aw  = g.luma_width;
      ah  = g.luma_height;
      pw  = g.luma_padded_width;
      pht = g.luma_padded_height;
    end else begin
      case (g.chroma_format)
        yep_pkg::FMT_411: begin
          aw = g.luma_width >> 2;
          ah = g.luma_height;
        end
        yep_pkg::FMT_420: begin
          aw = g.luma_width >> 1;
          ah = g.luma_height >> 1;
        end
        yep_pkg::FMT_422: begin
          aw = g.luma_width >> 1;
          ah = g.luma_height;
        end
        default: begin
          aw = g.luma_width;
          ah = g.luma_height;
        end
      endcase
      pw  = g.chroma_padded_width;
      pht = g.chroma_padded_height;
    end
    if (aw == 13'd0) aw = 13'd1;
    else if (aw > WCAP_W) aw = WCAP_W;
    if (ah == 13'd0) ah = 13'd1;
    else if (ah > HCAP_W) ah = HCAP_W;
    if (pw < aw) pw = aw;
    pad = pw - aw;
    if (pad > PAD_W) pad = PAD_W;
    pw = aw + pad;
    if (pw > WCAP_W) pw = WCAP_W;
    if (pht < ah) pht = ah;
    if (pht > HCAP_W) pht = HCAP_W;
    res.w   = aw;
    res.h   = ah;
    res.len = pw;
    res.ph  = pht;
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chroma_format        <= yep_pkg::FMT_420;
      cfg.luma_width           <= 13'd720;
      cfg.luma_height          <= 13'd576;
      cfg.luma_padded_width    <= 13'd720;
      cfg.luma_padded_height   <= 13'd576;
      cfg.chroma_padded_width  <= 13'd360;
      cfg.chroma_padded_height <= 13'd288;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        yep_pkg::REG_CHROMA_FORMAT: cfg.chroma_format        <= cfg_data[2:0];
        yep_pkg::REG_LUMA_WIDTH:    cfg.luma_width           <= cfg_data;
        yep_pkg::REG_LUMA_HEIGHT:   cfg.luma_height          <= cfg_data;
        yep_pkg::REG_LUMA_PAD_W:    cfg.luma_padded_width    <= cfg_data;
        yep_pkg::REG_LUMA_PAD_H:    cfg.luma_padded_height   <= cfg_data;
        yep_pkg::REG_CHROMA_PAD_W:  cfg.chroma_padded_width  <= cfg_data;
        yep_pkg::REG_CHROMA_PAD_H:  cfg.chroma_padded_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign geo      = plane_geo(plane_index != yep_pkg::PLANE_Y, cfg);
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign h_m1     = geo.h - 13'd1;
  assign w_m1     = geo.w - 13'd1;
  assign len_m1   = geo.len - 13'd1;
  assign ph_m1    = geo.ph - 13'd1;
  assign pad_run  = geo.len - geo.w;

  always_comb begin
    col_count_next   = col_count;
    row_count_next   = row_count;
    plane_index_next = plane_index;
    fill_phase_next  = fill_phase;
    push_valid       = 1'b0;
    finish           = 1'b0;
    r                = row_count;
    c                = col_count;
    row_end          = 1'b0;
    col_end          = 1'b0;
    push_job.is_fill    = in_cmd;
    push_job.value      = {in_sample, 2'b00};
    push_job.plane      = plane_index;
    push_job.row        = 12'd0;
    push_job.col        = 12'd0;
    push_job.count_m1   = '0;
    push_job.plane_done = 1'b0;
    push_job.frame_done = 1'b0;

    if (in_cmd == yep_pkg::CMD_BYTE) begin
      r = ({1'b0, row_count} < h_m1) ? row_count : h_m1[11:0];
      c = ({1'b0, col_count} < w_m1) ? col_count : w_m1[11:0];
      col_end = !(({1'b0, c} + 13'd1) < geo.w);
      row_end = !(({1'b0, r} + 13'd1) < geo.h);
      if (!fill_phase) begin
        push_valid = accept;
        if (!col_end) begin
          col_count_next = c + 12'd1;
        end else begin
          push_job.count_m1 = pad_run[yep_pkg::PAD_BITS-1:0];
          col_count_next    = 12'd0;
          if (!row_end) begin
            row_count_next = r + 12'd1;
          end else if (geo.ph > geo.h) begin
            fill_phase_next = 1'b1;
            row_count_next  = geo.h[11:0];
          end else begin
            finish = 1'b1;
          end
        end
      end
    end else begin
      r = ({1'b0, row_count} < ph_m1) ? row_count : ph_m1[11:0];
      c = ({1'b0, col_count} < len_m1) ? col_count : len_m1[11:0];
      col_end = !(({1'b0, c} + 13'd1) < geo.len);
      row_end = !(({1'b0, r} + 13'd1) < geo.ph);
      if (fill_phase) begin
        push_valid = accept;
        if (!col_end) begin
          col_count_next = c + 12'd1;
        end else if (!row_end) begin
          row_count_next = r + 12'd1;
          col_count_next = 12'd0;
        end else begin
          finish = 1'b1;
        end
      end
    end

    push_job.row = r;
    push_job.col = c;

    if (finish) begin
      push_job.plane_done = 1'b1;
      col_count_next      = 12'd0;
      row_count_next      = 12'd0;
      fill_phase_next     = 1'b0;
      if (plane_index == yep_pkg::PLANE_Y && cfg.chroma_format != yep_pkg::FMT_LUMA_ONLY) begin
        plane_index_next = yep_pkg::PLANE_U;
      end else if (plane_index == yep_pkg::PLANE_U) begin
        plane_index_next = yep_pkg::PLANE_V;
      end else begin
        push_job.frame_done = 1'b1;
        plane_index_next    = yep_pkg::PLANE_Y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= 12'd0;
      row_count   <= 12'd0;
      plane_index <= yep_pkg::PLANE_Y;
      fill_phase  <= 1'b0;
    end else if (push_valid) begin
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      plane_index <= plane_index_next;
      fill_phase  <= fill_phase_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/yep_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yep_queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module yep_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push_valid,
  input  yep_pkg::job_t    push_job,
  output logic             push_ready,
  output logic             head_valid,
  output yep_pkg::job_t    head_job,
  input  wire              pop
);

  yep_pkg::job_t               slots [yep_pkg::QDEPTH];
  logic [yep_pkg::QAW-1:0]     wr_ptr;
  logic [yep_pkg::QAW-1:0]     rd_ptr;
  logic [yep_pkg::QAW:0]       count;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = count != (yep_pkg::QAW + 1)'(yep_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/yep_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yep_back
// Expands each job into its results, one per cycle while the output is not
// stalled, keeps the line store and holds the output register.
// ----------------------------------------------------------------------------
module yep_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              head_valid,
  input  yep_pkg::job_t    head_job,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [9:0]       out_pixel,
  output logic [1:0]       out_plane,
  output logic [11:0]      out_row,
  output logic [11:0]      out_column,
  output logic             out_run_last,
  output logic             out_plane_done,
  output logic             out_frame_done
);

  localparam int WCAP = (MAX_WIDTH < yep_pkg::COORD_LIMIT) ? MAX_WIDTH : yep_pkg::COORD_LIMIT;
  localparam int AW   = $clog2(WCAP);

  logic [9:0]                  row_store [WCAP];
  logic [9:0]                  store_q;
  logic [yep_pkg::PAD_BITS-1:0] offset;
  logic                        issue;
  logic                        last;
  logic [11:0]                 col;
  logic [AW-1:0]               addr;
  logic                        out_is_fill;
  logic [9:0]                  out_value;

  assign issue = head_valid && (!out_valid || out_ready);
  assign last  = offset == head_job.count_m1;
  assign pop   = issue && last;
  assign col   = head_job.col + 12'(offset);
  assign addr  = col[AW-1:0];

  always_ff @(posedge clk) begin
    if (issue && !head_job.is_fill) begin
      row_store[addr] <= head_job.value;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && head_job.is_fill) begin
      store_q <= row_store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue) offset <= last ? '0 : offset + 1'b1;
      if (issue) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_is_fill    <= head_job.is_fill;
      out_value      <= head_job.value;
      out_plane      <= head_job.plane;
      out_row        <= head_job.row;
      out_column     <= col;
      out_run_last   <= last;
      out_plane_done <= last && head_job.plane_done;
      out_frame_done <= last && head_job.frame_done;
    end
  end

  assign out_pixel = out_is_fill ? store_q : out_value;

endmodule

`default_nettype wire

// File: rtl/yuv_edge_pad_expander.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_edge_pad_expander
// Expands 8-bit planar YUV bytes to 10-bit samples with right and bottom
// edge replication padding.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: cmd; tdata: sample
//   m_axis    out        tdata: pixel, row, column; tuser: plane, plane_done,
//                        frame_done; tlast: run_last
//   cfg       in         cfg_index selects one of seven registers
//
// One request is accepted per cycle while the job queue has room. Each job
// leaves one result per cycle while the output is not stalled; a byte that
// ends a row produces one result plus the right padding run. Fill reads of
// the line store are registered inside the output stage. Reset is
// synchronous and clears counters and the queue; the line store is not
// cleared. The queue holds four jobs, so the input keeps flowing while the
// output stalls until it fills.
// ----------------------------------------------------------------------------
module yuv_edge_pad_expander #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_RIGHT_PAD = 63
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] sample
  input  wire         s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [9:0] pixel, [21:10] row, [33:22] column
  output logic [3:0]  m_axis_tuser,   // [1:0] plane, [2] plane_done, [3] frame_done
  output logic        m_axis_tlast
);

  logic          push_valid;
  logic          push_ready;
  yep_pkg::job_t push_job;
  logic          head_valid;
  yep_pkg::job_t head_job;
  logic          pop;
  logic [9:0]    pixel;
  logic [1:0]    plane;
  logic [11:0]   row;
  logic [11:0]   column;
  logic          plane_done;
  logic          frame_done;

  yep_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_RIGHT_PAD (MAX_RIGHT_PAD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser),
    .in_sample  (s_axis_tdata),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  yep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  yep_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_pixel      (pixel),
    .out_plane      (plane),
    .out_row        (row),
    .out_column     (column),
    .out_run_last   (m_axis_tlast),
    .out_plane_done (plane_done),
    .out_frame_done (frame_done)
  );

  assign m_axis_tdata = {6'd0, column, row, pixel};
  assign m_axis_tuser = {frame_done, plane_done, plane};

endmodule

`default_nettype wire
